/* hw/rtl/lcrs_pkg.sv */
// shared types and constants of the lba to chs read splitter
// no dependencies
package lcrs_pkg;

  localparam int unsigned CHUNK_SECTORS       = 8;
  localparam int unsigned BIOS_CHUNK_LIMIT    = 7'h7f;
  localparam int unsigned MAX_REQUEST_SECTORS = 64;
  localparam int unsigned CHUNK_MAX           =
    (CHUNK_SECTORS < BIOS_CHUNK_LIMIT) ? CHUNK_SECTORS : BIOS_CHUNK_LIMIT;

  localparam int unsigned BLOCK_W = 32;
  localparam int unsigned SPT_W   = 6;
  localparam int unsigned HEADS_W = 9;
  localparam int unsigned CYLS_W  = 11;
  localparam int unsigned TOTAL_W = 7;
  localparam int unsigned CYL_W   = 10;
  localparam int unsigned HEAD_W  = 8;
  localparam int unsigned SECT_W  = 6;
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned DVS_W   = 9;

  localparam logic [1:0] REG_SPT   = 2'd0;
  localparam logic [1:0] REG_HEADS = 2'd1;
  localparam logic [1:0] REG_CYLS  = 2'd2;

  localparam logic [SPT_W-1:0]   SPT_RESET   = 6'd63;
  localparam logic [HEADS_W-1:0] HEADS_RESET = 9'd16;
  localparam logic [CYLS_W-1:0]  CYLS_RESET  = 11'd1024;
  localparam logic [HEADS_W-1:0] HEADS_MAX   = 9'd256;
  localparam logic [CYLS_W-1:0]  CYLS_MAX    = 11'd1024;

  localparam logic [0:0] STATUS_OK      = 1'b0;
  localparam logic [0:0] STATUS_CYL_ERR = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV1 = 4'b0010,
    ST_DIV2 = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

endpackage

/* hw/rtl/lcrs_div.sv */
// serial restoring divider, one quotient bit per cycle, 32-bit dividend, 9-bit divisor
// depends on lcrs_pkg
module lcrs_div
  import lcrs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [BLOCK_W-1:0] dividend,
  input  logic [DVS_W-1:0]   divisor,
  output logic               done,
  output logic [BLOCK_W-1:0] quotient,
  output logic [DVS_W-1:0]   remainder
);

  logic [BLOCK_W-1:0] dvd;
  logic [DVS_W-1:0]   dvs;
  logic [DVS_W-1:0]   rem;
  logic [4:0]         cnt;
  logic               running;

  logic [DVS_W:0]     rem_sh;
  logic               ge;
  logic [DVS_W:0]     rem_sub;

  assign rem_sh  = {rem, dvd[BLOCK_W-1]};
  assign ge      = rem_sh >= {1'b0, dvs};
  assign rem_sub = rem_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= running && (cnt == 5'd31);
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          running <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (running) begin
      dvd <= {dvd[BLOCK_W-2:0], ge};
      rem <= ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
    end
  end

  assign quotient  = dvd;
  assign remainder = rem;

endmodule

/* hw/rtl/lba_to_chs_read_splitter.sv */
// top level: splits a block read request into cylinder/head/sector chunk commands
// depends on lcrs_pkg and lcrs_div
//
// channel   dir  handshake            contents
// s_*       in   s_tvalid/s_tready    read request transaction
// m_*       out  m_tvalid/m_tready    chunk command transaction, tlast on final one
// cfg_*     in   cfg_valid/cfg_ready  geometry register write
//
// each chunk costs two passes of the shared serial divider plus control, and a stalled
// output holds the sequencer, so a new request is accepted only after the last chunk
// of the previous one has been issued; s_tready is high only between requests
// reset loads the default geometry, no clearing pass
// a stalled output holds in its register and the sequencer waits for it
module lba_to_chs_read_splitter
  import lcrs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // start_block[31:0], sector_total[38:32]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // cylinder[9:0], head[17:10], sector[23:18], chunk_sectors[27:24]
  output logic [0:0]  m_tuser,   // status[0]
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  state_t state;

  logic [SPT_W-1:0]   spt;
  logic [HEADS_W-1:0] heads;
  logic [CYLS_W-1:0]  cyls;

  logic [BLOCK_W-1:0] blk;
  logic [TOTAL_W-1:0] left;
  logic               empty;
  logic [SPT_W-1:0]   offs;
  logic [BLOCK_W-1:0] track;
  logic [HEAD_W-1:0]  head_r;
  logic               div_start;

  logic               div_done;
  logic [BLOCK_W-1:0] div_q;
  logic [DVS_W-1:0]   div_r;

  logic [SPT_W-1:0]   spt_eff;
  logic [HEADS_W-1:0] heads_eff;
  logic [CYLS_W-1:0]  cyls_eff;
  logic [TOTAL_W-1:0] req_total;
  logic [SPT_W-1:0]   room;
  logic [TOTAL_W-1:0] n_a;
  logic [TOTAL_W-1:0] n;
  logic               cyl_err;
  logic               out_free;
  logic               s_acc;

  assign spt_eff   = (spt == '0) ? SPT_W'(1) : spt;
  assign heads_eff = (heads == '0) ? HEADS_W'(1) : ((heads > HEADS_MAX) ? HEADS_MAX : heads);
  assign cyls_eff  = (cyls > CYLS_MAX) ? CYLS_MAX : cyls;
  assign req_total = (s_tdata[38:32] > TOTAL_W'(MAX_REQUEST_SECTORS))
                     ? TOTAL_W'(MAX_REQUEST_SECTORS) : s_tdata[38:32];

  assign room    = spt_eff - offs;
  assign n_a     = (left > TOTAL_W'(CHUNK_MAX)) ? TOTAL_W'(CHUNK_MAX) : left;
  assign n       = (n_a > {1'b0, room}) ? {1'b0, room} : n_a;
  assign cyl_err = div_q >= {{(BLOCK_W-CYLS_W){1'b0}}, cyls_eff};

  assign s_tready  = (state == ST_IDLE);
  assign s_acc     = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;

  lcrs_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  ((state == ST_DIV1) ? blk : track),
    .divisor   ((state == ST_DIV1) ? {{(DVS_W-SPT_W){1'b0}}, spt_eff} : heads_eff),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      spt   <= SPT_RESET;
      heads <= HEADS_RESET;
      cyls  <= CYLS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SPT:   spt   <= cfg_data[SPT_W-1:0];
        REG_HEADS: heads <= cfg_data[HEADS_W-1:0];
        REG_CYLS:  cyls  <= cfg_data;
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      div_start <= 1'b0;
      m_tvalid  <= 1'b0;
      blk       <= '0;
      left      <= '0;
      empty     <= 1'b0;
    end else begin
      div_start <= (s_acc && (req_total != '0)) ||
                   ((state == ST_DIV1) && div_done) ||
                   ((state == ST_EMIT) && out_free && !empty && !cyl_err && (left != n));
      if (m_tvalid && m_tready && (state != ST_EMIT)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_acc) begin
            blk   <= s_tdata[31:0];
            left  <= req_total;
            empty <= (req_total == '0);
            if (req_total == '0) begin
              state <= ST_EMIT;
            end else begin
              state <= ST_DIV1;
            end
          end
        end
        ST_DIV1: begin
          if (div_done) begin
            state <= ST_DIV2;
          end
        end
        ST_DIV2: begin
          if (div_done) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            if (empty || cyl_err) begin
              left  <= '0;
              state <= ST_IDLE;
            end else begin
              blk  <= blk + {{(BLOCK_W-TOTAL_W){1'b0}}, n};
              left <= left - n;
              if (left == n) begin
                state <= ST_IDLE;
              end else begin
                state <= ST_DIV1;
              end
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // operand capture from the divider
  always_ff @(posedge clk) begin
    if (state == ST_DIV1 && div_done) begin
      offs  <= div_r[SPT_W-1:0];
      track <= div_q;
    end
    if (state == ST_DIV2 && div_done) begin
      head_r <= div_r[HEAD_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (state == ST_EMIT && out_free) begin
      if (empty) begin
        m_tdata <= '0;
        m_tuser <= STATUS_OK;
        m_tlast <= 1'b1;
      end else if (cyl_err) begin
        m_tdata <= '0;
        m_tuser <= STATUS_CYL_ERR;
        m_tlast <= 1'b1;
      end else begin
        m_tdata <= {4'b0, n[CNT_W-1:0], offs + SPT_W'(1), head_r, div_q[CYL_W-1:0]};
        m_tuser <= STATUS_OK;
        m_tlast <= (left == n);
      end
    end
  end

  a_empty_req: assert property (@(posedge clk) disable iff (rst)
    s_acc && (s_tdata[38:32] == '0) |=> (state == ST_EMIT) && empty)
    else $error("empty request did not go straight to emit");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == STATUS_CYL_ERR) |-> m_tlast && (m_tdata == '0))
    else $error("error result not last or not zeroed");

  a_mid_chunk: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> (m_tdata[27:24] != '0) && (m_tuser == STATUS_OK))
    else $error("non-final chunk empty or flagged");

  a_div_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV1) || (state == ST_DIV2))
    else $error("divider finished outside a divide state");

  a_emit_stall: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) && !out_free |=> (state == ST_EMIT) && $stable(blk))
    else $error("sequencer moved on while output stalled");

endmodule

/* tb/sv/lba_to_chs_read_splitter_tb.sv */
// testbench for lba_to_chs_read_splitter: sends read requests, splits them in its own
// geometry model and checks every chunk command field by field
// depends on lcrs_pkg and the rtl of the splitter
module lba_to_chs_read_splitter_tb;
  import lcrs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CFG_IDX_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 80;

  typedef struct packed {
    logic [CYL_W-1:0]  cylinder;
    logic [HEAD_W-1:0] head;
    logic [SECT_W-1:0] sector;
    logic [CNT_W-1:0]  chunk_sectors;
    logic [0:0]        status;
    logic              last;
  } chunk_cmd_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [10:0] cfg_data = '0;

  logic rx_want = 1'b0;
  logic rx_hold = 1'b0;
  bit   tx_idle_on = 1'b1;
  bit   rx_idle_on = 1'b1;
  int   hold_cycles_req = 0;
  int   fail_count = 0;

  logic [SPT_W-1:0]   geo_spt = SPT_RESET;
  logic [HEADS_W-1:0] geo_heads = HEADS_RESET;
  logic [CYLS_W-1:0]  geo_cyls = CYLS_RESET;

  chunk_cmd_t chunk_cmds_due[$];

  assign m_tready = rx_want & ~rx_hold;

  lba_to_chs_read_splitter u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic void push_cmd(int unsigned cyl, int unsigned hd, int unsigned sect,
                                   int unsigned n, logic [0:0] status, logic last);
    chunk_cmd_t c;
    c.cylinder      = cyl[CYL_W-1:0];
    c.head          = hd[HEAD_W-1:0];
    c.sector        = sect[SECT_W-1:0];
    c.chunk_sectors = n[CNT_W-1:0];
    c.status        = status;
    c.last          = last;
    chunk_cmds_due.push_back(c);
  endfunction

  // splits one request under the current geometry into the chunk commands it must produce
  function automatic void split_request(logic [31:0] start, logic [TOTAL_W-1:0] total);
    int unsigned spt, heads, cyls, left, offs, track, n;
    logic [31:0] blk;
    spt   = (geo_spt == 0) ? 1 : geo_spt;
    heads = (geo_heads == 0) ? 1 : ((geo_heads > HEADS_MAX) ? HEADS_MAX : geo_heads);
    cyls  = (geo_cyls > CYLS_MAX) ? CYLS_MAX : geo_cyls;
    left  = (total > MAX_REQUEST_SECTORS) ? MAX_REQUEST_SECTORS : total;
    blk   = start;
    if (left == 0)
      push_cmd(0, 0, 0, 0, STATUS_OK, 1'b1);
    while (left > 0) begin
      offs  = blk % spt;
      track = blk / spt;
      if (track / heads >= cyls) begin
        push_cmd(0, 0, 0, 0, STATUS_CYL_ERR, 1'b1);
        left = 0;
      end else begin
        n = (left > CHUNK_MAX) ? CHUNK_MAX : left;
        if (offs + n > spt)
          n = spt - offs;
        blk  = blk + n;
        left = left - n;
        push_cmd(track / heads, track % heads, offs + 1, n, STATUS_OK, left == 0);
      end
    end
  endfunction

  // register write, valid left high for a following write
  task automatic cfg_xfer(input logic [1:0] idx, input logic [10:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SPT:   geo_spt = val[SPT_W-1:0];
      REG_HEADS: geo_heads = val[HEADS_W-1:0];
      REG_CYLS:  geo_cyls = val[CYLS_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_geometry(input logic [10:0] spt, input logic [10:0] heads,
                              input logic [10:0] cyls);
    cfg_xfer(REG_SPT, spt);
    cfg_xfer(REG_HEADS, heads);
    cfg_xfer(REG_CYLS, cyls);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_request(input logic [31:0] start, input logic [TOTAL_W-1:0] total);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  <= {1'b0, total, start};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    split_request(start, total);
    @(negedge clk);
  endtask

  task automatic wait_drained;
    s_tvalid <= 1'b0;
    while (chunk_cmds_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // default geometry 63/16/1024, disk of 1032192 blocks
  task automatic test_directed;
    send_request(32'd0, 7'd0);
    send_request(32'd0, 7'd1);
    send_request(32'd0, 7'd64);
    send_request(32'd100, 7'd127);
    send_request(32'd60, 7'd10);
    send_request(32'd1007, 7'd8);
    send_request(32'd1032191, 7'd2);
    send_request(32'd1032192, 7'd1);
    send_request(32'hffff_ffff, 7'd64);
    send_request(32'h0000_ffff, 7'd42);
    wait_drained();
  endtask

  task automatic test_geometry_extremes;
    cfg_xfer(CFG_IDX_UNUSED, 11'h7ff);
    set_geometry(11'h001, 11'h001, 11'h000);
    send_request(32'd0, 7'd0);
    send_request(32'd0, 7'd3);
    send_request(32'd7, 7'd1);
    wait_drained();
    // zero sectors and heads read as one, cylinder count saturates
    set_geometry(11'h7c0, 11'h600, 11'h7ff);
    send_request(32'd1020, 7'd6);
    send_request(32'd0, 7'd127);
    send_request(32'd500, 7'd9);
    wait_drained();
    // head count saturates to 256
    set_geometry(11'h7ff, 11'h1ff, 11'h400);
    send_request(32'd16515069, 7'd8);
    send_request(32'd16064, 7'd5);
    send_request(32'd0, 7'd8);
    wait_drained();
  endtask

  task automatic test_backpressure;
    hold_cycles_req = 500;
    repeat (6) send_request(32'd0, 7'd64);
    wait_drained();
  endtask

  task automatic test_random;
    int unsigned spt, heads, cyls, disk, pick;
    logic [31:0] blk;
    logic [TOTAL_W-1:0] total;
    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 0) begin
        spt = $urandom_range(1, 4);
        heads = $urandom_range(1, 3);
        cyls = $urandom_range(1, 8);
      end else begin
        spt = $urandom_range(1, 63);
        heads = $urandom_range(1, 256);
        cyls = $urandom_range(1, 1024);
      end
      set_geometry(11'(spt), 11'(heads), 11'(cyls));
      disk = spt * heads * cyls;
      tx_idle_on = (phase == 5) ? 1'b0 : 1'($urandom_range(0, 1));
      rx_idle_on = (phase == 5) ? 1'b0 : 1'($urandom_range(0, 1));
      if (phase == 2) begin
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
      end
      for (int i = 0; i < 64; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
          blk = $urandom_range(0, disk - 1);
          total = (spt < CHUNK_MAX) ? TOTAL_W'($urandom_range(1, 16))
                                    : TOTAL_W'($urandom_range(1, 64));
        end else if (pick < 80) begin
          blk = (disk > 20) ? disk - $urandom_range(1, 20) : $urandom_range(0, disk - 1);
          total = TOTAL_W'($urandom_range(1, 16));
        end else if (pick < 88) begin
          blk = $urandom_range(0, disk - 1);
          total = '0;
        end else begin
          blk = $urandom();
          total = TOTAL_W'($urandom_range(0, 127));
        end
        send_request(blk, total);
      end
      wait_drained();
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  initial begin : rx_drive
    int gap;
    while (rst) @(negedge clk);
    forever begin
      gap = rx_idle_on ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
        rx_want <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      rx_want <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
      @(negedge clk);
    end
  end

  initial begin : rx_hold_ctl
    forever begin
      @(negedge clk);
      if (hold_cycles_req > 0) begin
        rx_hold <= 1'b1;
        repeat (hold_cycles_req) @(negedge clk);
        rx_hold <= 1'b0;
        hold_cycles_req = 0;
      end
    end
  end

  always @(posedge clk) begin : check_chunks
    chunk_cmd_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (chunk_cmds_due.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected chunk cmd: cyl=%0d head=%0d sect=%0d n=%0d st=%0d last=%0d",
                   m_tdata[9:0], m_tdata[17:10], m_tdata[23:18], m_tdata[27:24],
                   m_tuser, m_tlast);
      end else begin
        want = chunk_cmds_due.pop_front();
        if (m_tdata[9:0] !== want.cylinder || m_tdata[17:10] !== want.head ||
            m_tdata[23:18] !== want.sector || m_tdata[27:24] !== want.chunk_sectors ||
            m_tuser !== want.status || m_tlast !== want.last) begin
          fail_count++;
          if (fail_count <= 10)
            $display({"chunk cmd mismatch: exp cyl=%0d head=%0d sect=%0d n=%0d st=%0d ",
                      "last=%0d, got cyl=%0d head=%0d sect=%0d n=%0d st=%0d last=%0d"},
                     want.cylinder, want.head, want.sector, want.chunk_sectors,
                     want.status, want.last, m_tdata[9:0], m_tdata[17:10],
                     m_tdata[23:18], m_tdata[27:24], m_tuser, m_tlast);
        end
      end
    end
  end

  initial begin : watchdog
    #100_000_000;
    $display("[lba_to_chs_read_splitter] ERROR");
    $finish;
  end

  initial begin : main_seq
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_geometry_extremes();
    test_backpressure();
    test_random();
    if (fail_count == 0 && chunk_cmds_due.size() == 0) begin
      $display("[lba_to_chs_read_splitter] OK");
    end else begin
      $display("[lba_to_chs_read_splitter] ERROR");
    end
    $finish;
  end

endmodule
